[rtl/ophalloc_pkg.sv]
// ----------------------------------------------------------------------------
// Handle allocator package
// Field widths, operation and status codes, and the controller command.
// ----------------------------------------------------------------------------
package ophalloc_pkg;

    localparam int HANDLE_W     = 8;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int HANDLE_SPACE = 256;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY   = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } ophalloc_cmd_t;

endpackage

[rtl/ophalloc_ctrl.sv]
// ----------------------------------------------------------------------------
// Handle allocator controller
// Sequences one request at a time: capture, execute, and hold the result beat.
// ----------------------------------------------------------------------------
module ophalloc_ctrl
    import ophalloc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output ophalloc_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   s_ready_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next   = S_EXEC;
                    s_ready_next = 1'b0;
                end
            end
            S_EXEC: begin
                state_next   = S_HOLD;
                m_valid_next = 1'b1;
            end
            S_HOLD: begin
                if (m_ready) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b0;
                    s_ready_next = 1'b1;
                end
            end
            default: begin
                state_next   = S_IDLE;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready  = s_ready_reg;
    assign m_valid  = m_valid_reg;
    assign cmd.load = s_valid && s_ready_reg;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

[rtl/ophalloc_dp.sv]
// ----------------------------------------------------------------------------
// Handle allocator datapath
// Free-handle queue memory, in-use bitmap, fresh-handle counter and result.
// ----------------------------------------------------------------------------
module ophalloc_dp
    import ophalloc_pkg::*;
#(
    parameter int SLOTS = 256
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ophalloc_cmd_t       cmd,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [HANDLE_W-1:0] s_handle_in,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic                m_granted,
    output logic [STATUS_W-1:0] m_status
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [IDX_W-1:0]    queue_mem [SLOTS];
    logic [IDX_W-1:0]    rd_data_reg;

    logic [OP_W-1:0]     op_reg;
    logic [HANDLE_W-1:0] hin_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_reg;
    logic [IDX_W-1:0]    tail_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    fresh_reg;
    logic [CNT_W-1:0]    fresh_next;
    logic [SLOTS-1:0]    in_use_reg;
    logic [SLOTS-1:0]    in_use_next;

    logic [HANDLE_W-1:0] handle_out_reg;
    logic [HANDLE_W-1:0] handle_out_next;
    logic                granted_reg;
    logic                granted_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                is_get;
    logic                pop_ok;
    logic                fresh_ok;
    logic                free_ok;
    logic [IDX_W-1:0]    hin_idx;
    logic [IDX_W-1:0]    grant_idx;

    assign hin_idx   = hin_reg[IDX_W-1:0];
    assign is_get    = (op_reg == OP_ALLOC) || (op_reg == OP_TRY);
    assign pop_ok    = is_get && (count_reg != '0);
    assign fresh_ok  = (op_reg == OP_ALLOC) && (count_reg == '0)
                       && (fresh_reg < CNT_W'(SLOTS));
    assign free_ok   = (op_reg == OP_FREE) && ({1'b0, hin_reg} < (HANDLE_W + 1)'(SLOTS))
                       && in_use_reg[hin_idx] && (count_reg < CNT_W'(SLOTS));
    assign grant_idx = pop_ok ? rd_data_reg : fresh_reg[IDX_W-1:0];

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        in_use_next     = in_use_reg;
        handle_out_next = handle_out_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        if (cmd.exec) begin
            handle_out_next = '0;
            granted_next    = 1'b0;
            status_next     = ST_OK;
            if (is_get) begin
                if (pop_ok || fresh_ok) begin
                    handle_out_next        = HANDLE_W'(grant_idx);
                    granted_next           = 1'b1;
                    in_use_next[grant_idx] = 1'b1;
                    if (pop_ok) begin
                        head_next  = (head_reg == IDX_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end else begin
                        fresh_next = fresh_reg + 1'b1;
                    end
                end else if (op_reg == OP_TRY) begin
                    status_next = ST_NONE_FREED;
                end else begin
                    status_next = ST_EXHAUSTED;
                end
            end else if (op_reg == OP_FREE) begin
                if (free_ok) begin
                    tail_next            = (tail_reg == IDX_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                    count_next           = count_reg + 1'b1;
                    in_use_next[hin_idx] = 1'b0;
                end else begin
                    status_next = ST_NOT_ALLOCATED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && free_ok) begin
            queue_mem[tail_reg] <= hin_idx;
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_operation;
            hin_reg <= s_handle_in;
        end
        handle_out_reg <= handle_out_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            fresh_reg  <= '0;
            in_use_reg <= '0;
        end else begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            fresh_reg  <= fresh_next;
            in_use_reg <= in_use_next;
        end
    end

    assign m_handle_out = handle_out_reg;
    assign m_granted    = granted_reg;
    assign m_status     = status_reg;

endmodule

[rtl/object_pool_handle_allocator_core.sv]
// ----------------------------------------------------------------------------
// Object pool handle allocator
// Hands out slot handles of a fixed pool and takes them back.
//
// Usage: each beat on the s_ channel is one request: allocate, try_allocate
// (reuse a freed handle only) or deallocate of s_handle_in. Every request
// returns exactly one beat on the m_ channel with the granted handle, a
// granted flag and a status code. Released handles are reused oldest first;
// when none waits, allocate issues the lowest handle never issued before.
// The pool holds min(POOL_SLOTS, 256) handles.
// One request is in flight at a time: a new request is taken only after the
// result beat of the last one has been taken. The controller runs capture,
// execute and output in turn, and the free-handle queue memory is read ahead
// of the execute step through its registered port.
// Reset clears the in-use bitmap, the queue pointers and the fresh counter;
// the queue memory itself needs no clearing.
// When the receiver stalls, the result beat holds and s_ready stays low.
// ----------------------------------------------------------------------------
module object_pool_handle_allocator_core
    import ophalloc_pkg::*;
#(
    parameter int POOL_SLOTS = 256
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [HANDLE_W-1:0] s_handle_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic                m_granted,
    output logic [STATUS_W-1:0] m_status
);

    localparam int SLOTS = (POOL_SLOTS < HANDLE_SPACE) ? POOL_SLOTS : HANDLE_SPACE;

    ophalloc_cmd_t cmd;

    ophalloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ophalloc_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_operation  (s_operation),
        .s_handle_in  (s_handle_in),
        .m_handle_out (m_handle_out),
        .m_granted    (m_granted),
        .m_status     (m_status)
    );

endmodule

[rtl/ophalloc_checker.sv]
// ----------------------------------------------------------------------------
// Handle allocator port checker
// Watches the top-level ports for ordering and result consistency.
// ----------------------------------------------------------------------------
module ophalloc_checker
    import ophalloc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [HANDLE_W-1:0] m_handle_out,
    input logic                m_granted,
    input logic [STATUS_W-1:0] m_status
);

    // A new request is never taken while a result beat is pending.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_granted |-> m_status == ST_OK)
        else $error("granted result with error status");

    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_granted |-> m_handle_out == '0)
        else $error("handle nonzero without grant");

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 m_valid)
        else $error("result beat not produced after request");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_handle_out)
        && $stable(m_granted) && $stable(m_status))
        else $error("stalled result beat changed");

endmodule

bind object_pool_handle_allocator_core ophalloc_checker u_ophalloc_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Handle allocator testbench
// Sends allocate, try_allocate, deallocate and unused-code requests to the
// allocator core with random gaps on the request side and random stalls on
// the result side. A built-in model of the free-handle queue, the in-use
// bitmap and the fresh-handle counter predicts every result beat, and the
// monitor compares each one field by field. The random part first fills
// the pool until it runs dry, then churns through releases and reuse.
// ----------------------------------------------------------------------------
module tb_top
    import ophalloc_pkg::*;
;

    localparam int              SLOT_COUNT = 256;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] hin;
    } request_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                granted;
        logic [STATUS_W-1:0] status;
    } grant_t;

    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation  = '0;
    logic [HANDLE_W-1:0] s_handle_in  = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [HANDLE_W-1:0] m_handle_out;
    logic                m_granted;
    logic [STATUS_W-1:0] m_status;

    request_t pending_requests[$];
    grant_t   grant_expected[$];

    logic [HANDLE_W-1:0] freed_fifo [HANDLE_SPACE];
    logic [HANDLE_W-1:0] freed_rd;
    logic [HANDLE_W-1:0] freed_wr;
    logic [8:0]          freed_count;
    logic                in_use [HANDLE_SPACE];
    logic [8:0]          fresh_next;

    int exhaust_hits   = 0;
    int requests_sent  = 0;
    int mismatch_count = 0;
    int send_hold      = 0;
    int recv_hold      = 0;

    object_pool_handle_allocator_core #(
        .POOL_SLOTS (SLOT_COUNT)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_handle_in  (s_handle_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_handle_out (m_handle_out),
        .m_granted    (m_granted),
        .m_status     (m_status)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int draw_pause();
        if ($urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic predict_grant(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] hin);
        grant_t              r;
        logic [HANDLE_W-1:0] h;
        logic                take;
        r    = '{handle: '0, granted: 1'b0, status: ST_OK};
        h    = '0;
        take = 1'b0;
        if (op == OP_ALLOC || op == OP_TRY) begin
            if (freed_count > 0) begin
                h           = freed_fifo[freed_rd];
                freed_rd    = freed_rd + 1'b1;
                freed_count = freed_count - 1'b1;
                take        = 1'b1;
            end else if (op == OP_TRY) begin
                r.status = ST_NONE_FREED;
            end else if (fresh_next < SLOT_COUNT) begin
                h          = fresh_next[HANDLE_W-1:0];
                fresh_next = fresh_next + 1'b1;
                take       = 1'b1;
            end else begin
                r.status     = ST_EXHAUSTED;
                exhaust_hits = exhaust_hits + 1;
            end
            if (take) begin
                in_use[h] = 1'b1;
                r.handle  = h;
                r.granted = 1'b1;
            end
        end else if (op == OP_FREE) begin
            if (int'(hin) >= SLOT_COUNT || !in_use[hin] || freed_count >= HANDLE_SPACE) begin
                r.status = ST_NOT_ALLOCATED;
            end else begin
                freed_fifo[freed_wr] = hin;
                freed_wr             = freed_wr + 1'b1;
                freed_count          = freed_count + 1'b1;
                in_use[hin]          = 1'b0;
            end
        end
        grant_expected.push_back(r);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_grant(s_operation, s_handle_in);
            end
            if (!(s_valid && !s_ready)) begin
                if (send_hold > 0) begin
                    send_hold = send_hold - 1;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    request_t req;
                    req = pending_requests.pop_front();
                    s_operation <= req.op;
                    s_handle_in <= req.hin;
                    s_valid     <= 1'b1;
                    send_hold   = draw_pause();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (grant_expected.size() == 0) begin
                    $error("unexpected result beat: handle_out %0d granted %0d status %0d",
                           m_handle_out, m_granted, m_status);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    grant_t e;
                    e = grant_expected.pop_front();
                    if (m_handle_out !== e.handle) begin
                        $error("handle_out: expected %0d, actual %0d", e.handle, m_handle_out);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_granted !== e.granted) begin
                        $error("granted: expected %0d, actual %0d", e.granted, m_granted);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_status !== e.status) begin
                        $error("status: expected %0d, actual %0d", e.status, m_status);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                recv_hold = draw_pause();
            end
            if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] hin);
        request_t req;
        req.op  = op;
        req.hin = hin;
        pending_requests.push_back(req);
        requests_sent = requests_sent + 1;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || grant_expected.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Looks for an allocated handle, starting at a random slot.
    function automatic logic [HANDLE_W-1:0] pick_live();
        int start;
        int idx;
        start = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++) begin
            idx = (start + k) % SLOT_COUNT;
            if (in_use[idx]) begin
                return idx[HANDLE_W-1:0];
            end
        end
        return start[HANDLE_W-1:0];
    endfunction

    task automatic run_batch(input int w_alloc, input int w_try, input int w_live,
                             input int w_any);
        int r;
        for (int k = 0; k < 8; k++) begin
            r = $urandom_range(0, 99);
            if (r < w_alloc) begin
                queue_request(OP_ALLOC, HANDLE_W'($urandom_range(0, 255)));
            end else if (r < w_alloc + w_try) begin
                queue_request(OP_TRY, HANDLE_W'($urandom_range(0, 255)));
            end else if (r < w_alloc + w_try + w_live) begin
                queue_request(OP_FREE, pick_live());
            end else if (r < w_alloc + w_try + w_live + w_any) begin
                queue_request(OP_FREE, HANDLE_W'($urandom_range(0, 255)));
            end else begin
                queue_request(OP_UNUSED, HANDLE_W'($urandom_range(0, 255)));
            end
        end
        wait_drained();
    endtask

    initial begin
        freed_rd    = '0;
        freed_wr    = '0;
        freed_count = '0;
        fresh_next  = '0;
        for (int i = 0; i < HANDLE_SPACE; i++) begin
            in_use[i] = 1'b0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty queue, releases of unallocated handles and the unused code come first.
        queue_request(OP_TRY, 8'd0);
        queue_request(OP_FREE, 8'd0);
        queue_request(OP_FREE, 8'd255);
        queue_request(OP_UNUSED, 8'd255);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_ALLOC, 8'd255);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_FREE, 8'd2);
        queue_request(OP_FREE, 8'd0);
        queue_request(OP_FREE, 8'd2);
        queue_request(OP_TRY, 8'd255);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_TRY, 8'd0);
        queue_request(OP_FREE, 8'd3);
        queue_request(OP_FREE, 8'd1);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_ALLOC, 8'd0);
        queue_request(OP_FREE, 8'd170);
        queue_request(OP_UNUSED, 8'd0);
        wait_drained();

        // Fill the pool until allocation runs dry six times or 420 requests have been sent.
        while (exhaust_hits < 6 && requests_sent < 420) begin
            run_batch(88, 4, 4, 0);
        end

        // Churn: releases and reuse in the full and near-empty queue states.
        repeat (19) begin
            run_batch(25, 20, 45, 5);
        end

        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && grant_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/ophalloc_pkg.sv
rtl/ophalloc_ctrl.sv
rtl/ophalloc_dp.sv
rtl/object_pool_handle_allocator_core.sv
rtl/ophalloc_checker.sv
tb/tb_top.sv
